/* rtl/core/hdcv_pkg.sv */
// Shared types and constants of the HSV dominant-colour vote block.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package hdcv_pkg;

    // Region size bound and the counter limit it implies
    localparam int MAX_REGION_PIXELS = 1048576;
    localparam int CNT_W             = 20;
    localparam int NUM_COLORS        = 6;
    localparam int IDX_W             = $clog2(NUM_COLORS);

    localparam logic [CNT_W-1:0] COUNT_LIMIT =
        ((longint'(MAX_REGION_PIXELS) - 1) < ((longint'(1) << CNT_W) - 1)) ?
        CNT_W'(longint'(MAX_REGION_PIXELS) - 1) : {CNT_W{1'b1}};

    // Colour codes
    localparam logic [2:0] C_RED    = 3'd0;
    localparam logic [2:0] C_BLUE   = 3'd1;
    localparam logic [2:0] C_YELLOW = 3'd2;
    localparam logic [2:0] C_GREEN  = 3'd3;
    localparam logic [2:0] C_BLACK  = 3'd4;
    localparam logic [2:0] C_WHITE  = 3'd5;
    localparam logic [2:0] C_NONE   = 3'd6;

    // Hue bands, halved-degree scale
    localparam logic [7:0] HUE_RED_LO_MAX  = 8'd10;
    localparam logic [7:0] HUE_RED_HI_MIN  = 8'd170;
    localparam logic [7:0] HUE_YELLOW_MIN  = 8'd20;
    localparam logic [7:0] HUE_YELLOW_MAX  = 8'd35;
    localparam logic [7:0] HUE_GREEN_MAX   = 8'd85;
    localparam logic [7:0] HUE_BLUE_ABOVE  = 8'd90;
    localparam logic [7:0] HUE_BLUE_MAX    = 8'd130;

    // Register map
    localparam int         NUM_REGS     = 4;
    localparam int         PADDR_W      = 4;
    localparam logic [1:0] REG_SAT_MIN  = 2'd0;
    localparam logic [1:0] REG_VAL_MIN  = 2'd1;
    localparam logic [1:0] REG_DARK     = 2'd2;
    localparam logic [1:0] REG_BRIGHT   = 2'd3;

    localparam logic [7:0] SAT_MIN_RST  = 8'd60;
    localparam logic [7:0] VAL_MIN_RST  = 8'd60;
    localparam logic [7:0] DARK_RST     = 8'd100;
    localparam logic [7:0] BRIGHT_RST   = 8'd200;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] brightness;
        logic       last_pixel;
    } t_pixel;

    typedef struct packed {
        logic [2:0]       color_code;
        logic [CNT_W-1:0] winning_count;
    } t_result;

    typedef struct packed {
        logic [7:0] saturation_min;
        logic [7:0] value_min;
        logic [7:0] dark_limit;
        logic [7:0] bright_limit;
    } t_cfg;

    typedef struct packed {
        logic count_en;    // count the accepted pixel
        logic scan_start;  // restart the maximum search
        logic scan_step;   // compare one counter
        logic load_out;    // load the result and clear the counters
    } t_dp_cmd;

    typedef struct packed {
        logic scan_end;    // the current step is the last counter
    } t_dp_status;

endpackage

`default_nettype wire

/* rtl/core/hsv_dominant_color_vote.sv */
// Dominant-colour vote over HSV pixel regions; top level.
// Throughput: one pixel per cycle inside a region.
// Region end: after the last pixel is taken, a six-step serial search over the
// counters runs and the result register is then loaded; no pixel is taken
// during the search and load or while a finished region waits for the result
// register to drain.
// Reset (synchronous, active low) clears counters and flags and sets thresholds to their defaults.
`default_nettype none

module hsv_dominant_color_vote
    import hdcv_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire t_pixel             i_pixel,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output t_result                 o_result,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    t_cfg       w_cfg;
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    hdcv_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    hdcv_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_last_pixel (i_pixel.last_pixel),
        .o_ready      (o_ready),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .i_status     (w_status),
        .o_cmd        (w_cmd)
    );

    hdcv_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_pixel  (i_pixel),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

/* rtl/core/hdcv_cfg_regs.sv */
// Threshold registers behind the APB-style configuration port.
// Depends on hdcv_pkg.
`default_nettype none

module hdcv_cfg_regs
    import hdcv_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.saturation_min <= SAT_MIN_RST;
            r_cfg.value_min      <= VAL_MIN_RST;
            r_cfg.dark_limit     <= DARK_RST;
            r_cfg.bright_limit   <= BRIGHT_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_SAT_MIN: r_cfg.saturation_min <= pwdata[7:0];
                REG_VAL_MIN: r_cfg.value_min      <= pwdata[7:0];
                REG_DARK:    r_cfg.dark_limit     <= pwdata[7:0];
                REG_BRIGHT:  r_cfg.bright_limit   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_SAT_MIN: prdata = {24'd0, r_cfg.saturation_min};
            REG_VAL_MIN: prdata = {24'd0, r_cfg.value_min};
            REG_DARK:    prdata = {24'd0, r_cfg.dark_limit};
            REG_BRIGHT:  prdata = {24'd0, r_cfg.bright_limit};
            default:     prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* rtl/core/hdcv_datapath.sv */
// Datapath: pixel classifier, six saturating vote counters, serial maximum
// search and the result register. Depends on hdcv_pkg.
`default_nettype none

module hdcv_datapath
    import hdcv_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cfg    i_cfg,
    input  wire t_pixel  i_pixel,
    input  wire t_dp_cmd i_cmd,
    output t_dp_status   o_status,
    output t_result      o_result
);

    logic [CNT_W-1:0] r_cnt [NUM_COLORS];
    logic [IDX_W-1:0] r_idx;
    logic [2:0]       r_best;
    logic [CNT_W-1:0] r_best_cnt;
    t_result          r_result;

    logic [2:0]       w_class;
    logic [CNT_W-1:0] w_sel_cnt;
    logic             w_achrom;

    // Classify the pixel against the thresholds and hue bands
    always_comb begin
        w_achrom = (i_pixel.saturation < i_cfg.saturation_min) ||
                   (i_pixel.brightness < i_cfg.value_min);
        if (w_achrom) begin
            if (i_pixel.brightness < i_cfg.dark_limit) begin
                w_class = C_BLACK;
            end else if (i_pixel.brightness > i_cfg.bright_limit) begin
                w_class = C_WHITE;
            end else begin
                w_class = C_NONE;
            end
        end else if (i_pixel.hue <= HUE_RED_LO_MAX || i_pixel.hue >= HUE_RED_HI_MIN) begin
            w_class = C_RED;
        end else if (i_pixel.hue >= HUE_YELLOW_MIN && i_pixel.hue <= HUE_YELLOW_MAX) begin
            w_class = C_YELLOW;
        end else if (i_pixel.hue > HUE_YELLOW_MAX && i_pixel.hue <= HUE_GREEN_MAX) begin
            w_class = C_GREEN;
        end else if (i_pixel.hue > HUE_BLUE_ABOVE && i_pixel.hue <= HUE_BLUE_MAX) begin
            w_class = C_BLUE;
        end else begin
            w_class = C_NONE;
        end
    end

    // One counter per colour, each with its own increment
    for (genvar g = 0; g < NUM_COLORS; g++) begin : g_cnt
        always_ff @(posedge i_clk) begin
            if (!i_rst_n || i_cmd.load_out) begin
                r_cnt[g] <= '0;
            end else if (i_cmd.count_en && w_class == 3'(g) &&
                         r_cnt[g] < COUNT_LIMIT) begin
                r_cnt[g] <= r_cnt[g] + CNT_W'(1);
            end
        end
    end

    assign w_sel_cnt         = r_cnt[r_idx];
    assign o_status.scan_end = (r_idx == IDX_W'(NUM_COLORS - 1));

    // Serial search; strict compare keeps the earlier colour on a tie
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_idx      <= '0;
            r_best     <= C_RED;
            r_best_cnt <= '0;
        end else if (i_cmd.scan_step) begin
            if (w_sel_cnt > r_best_cnt) begin
                r_best     <= 3'(r_idx);
                r_best_cnt <= w_sel_cnt;
            end
            if (!o_status.scan_end) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_result.color_code    <= (r_best_cnt == '0) ? C_NONE : r_best;
            r_result.winning_count <= r_best_cnt;
        end
    end

    assign o_result = r_result;

endmodule

`default_nettype wire

/* rtl/core/hdcv_ctrl.sv */
// Controller: accumulate, search and hand-off sequencing plus the result
// valid flag. Depends on hdcv_pkg.
`default_nettype none

module hdcv_ctrl
    import hdcv_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic       i_last_pixel,
    output logic            o_ready,
    output logic            o_valid,
    input  wire logic       i_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    localparam logic [1:0] S_ACCUM = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DONE  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_accept;
    logic       w_out_free;

    assign o_ready    = (r_state == S_ACCUM);
    assign w_accept   = i_valid & o_ready;
    assign w_out_free = ~r_out_valid | i_ready;

    always_comb begin
        o_cmd.count_en   = w_accept;
        o_cmd.scan_start = w_accept & i_last_pixel;
        o_cmd.scan_step  = (r_state == S_SCAN);
        o_cmd.load_out   = (r_state == S_DONE) & w_out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_ACCUM: if (w_accept && i_last_pixel) n_state = S_SCAN;
            S_SCAN:  if (i_status.scan_end)        n_state = S_DONE;
            S_DONE:  if (w_out_free)               n_state = S_ACCUM;
            default: n_state = S_ACCUM;
        endcase
    end

    // Hold the result until taken; a new load wins over a drain
    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACCUM;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire
